>>> rtl/gpop_pkg.sv
// Shared types and constants for the path price / option payoff block.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package gpop_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_PREMIUM       = 3'd0;
    localparam logic [2:0] REG_INITIAL_PRICE = 3'd1;
    localparam logic [2:0] REG_STRIKE        = 3'd2;
    localparam logic [2:0] REG_DRIFT_STEP    = 3'd3;
    localparam logic [2:0] REG_VOL_STEP      = 3'd4;
    localparam logic [2:0] REG_OPTION_IS_PUT = 3'd5;
    localparam logic [2:0] REG_STEP_COUNT    = 3'd6;

    // Result kinds
    localparam logic [1:0] KIND_PREMIUM = 2'd0;
    localparam logic [1:0] KIND_PRICE   = 2'd1;
    localparam logic [1:0] KIND_PAYOFF  = 2'd2;

    // Fixed-point constants
    localparam int EXP_FRAC = 28;
    localparam int XW       = 38;                        // exponent width, Q.28 signed
    localparam logic [27:0] LN2_Q28   = 28'd186065280;   // ln 2 in Q.28
    localparam logic [20:0] RECIP_LN2 = 21'd1512775;     // floor(2^48 / LN2_Q28)

    // Datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_P     = 4'd2;
    localparam logic [3:0] OP_X     = 4'd3;
    localparam logic [3:0] OP_KEST  = 4'd4;
    localparam logic [3:0] OP_R     = 4'd5;
    localparam logic [3:0] OP_CORR  = 4'd6;
    localparam logic [3:0] OP_EXPM  = 4'd7;
    localparam logic [3:0] OP_EXPD  = 4'd8;
    localparam logic [3:0] OP_PMUL  = 4'd9;
    localparam logic [3:0] OP_SCALE = 4'd10;
    localparam logic [3:0] OP_FIN   = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic       start;      // first step of a path: reload the price
        logic [2:0] n;          // Horner divisor
        logic       path_end;   // step ends the path: form the payoff
    } gpop_cmd_t;

    typedef struct packed {
        logic       load;
        logic       sel_premium;
        logic [1:0] kind;
        logic       last;
    } gpop_emit_t;

endpackage

`default_nettype wire

>>> rtl/gpop_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// No dependencies.
`default_nettype none

interface gpop_in_if #(parameter int SAMPLE_WIDTH = 16) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] normal_sample;
    modport source (output valid, output normal_sample, input ready);
    modport sink   (input valid, input normal_sample, output ready);
endinterface

interface gpop_out_if ();
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic [1:0]  kind;
    logic        last;
    modport source (output valid, output value, output kind, output last, input ready);
    modport sink   (input valid, input value, input kind, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/gpop_ctrl.sv
// Step sequencer: accepts samples, walks the datapath through one step, emits results.
// Depends on gpop_pkg.
`default_nettype none

module gpop_ctrl
    import gpop_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        out_free,
    input  wire logic [15:0] step_count,
    output gpop_cmd_t        cmd,
    output gpop_emit_t       emit
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREM  = 4'd1;
    localparam logic [3:0] S_P     = 4'd2;
    localparam logic [3:0] S_X     = 4'd3;
    localparam logic [3:0] S_KEST  = 4'd4;
    localparam logic [3:0] S_R     = 4'd5;
    localparam logic [3:0] S_CORR  = 4'd6;
    localparam logic [3:0] S_EXPM  = 4'd7;
    localparam logic [3:0] S_EXPD  = 4'd8;
    localparam logic [3:0] S_PMUL  = 4'd9;
    localparam logic [3:0] S_SCALE = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;
    localparam logic [3:0] S_EMIT  = 4'd12;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  n_reg, n_next;
    logic [15:0] step_reg, step_next;
    logic        end_reg, end_next;
    logic [15:0] steps;
    logic [15:0] step_inc;
    logic        path_end;

    assign steps    = (step_count == 16'd0) ? 16'd1 : step_count;
    assign step_inc = step_reg + 16'd1;
    assign path_end = (step_inc >= steps) || (step_inc == 16'd0);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        end_next   = end_reg;
        in_ready   = 1'b0;
        cmd        = '{op: OP_NONE, start: 1'b0, n: n_reg, path_end: end_reg};
        emit       = '{load: 1'b0, sel_premium: 1'b0, kind: KIND_PRICE, last: 1'b0};
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op    = OP_LOAD;
                    cmd.start = (step_reg == 16'd0);
                    if (step_reg == 16'd0)
                    begin
                        if (out_free)
                        begin
                            emit = '{load: 1'b1, sel_premium: 1'b1, kind: KIND_PREMIUM,
                                     last: 1'b0};
                            state_next = S_P;
                        end
                        else
                        begin
                            state_next = S_PREM;
                        end
                    end
                    else
                    begin
                        state_next = S_P;
                    end
                end
            end
            S_PREM:
            begin
                if (out_free)
                begin
                    emit = '{load: 1'b1, sel_premium: 1'b1, kind: KIND_PREMIUM, last: 1'b0};
                    state_next = S_P;
                end
            end
            S_P:
            begin
                cmd.op     = OP_P;
                state_next = S_X;
            end
            S_X:
            begin
                cmd.op     = OP_X;
                state_next = S_KEST;
            end
            S_KEST:
            begin
                cmd.op     = OP_KEST;
                state_next = S_R;
            end
            S_R:
            begin
                cmd.op     = OP_R;
                state_next = S_CORR;
            end
            S_CORR:
            begin
                cmd.op     = OP_CORR;
                n_next     = 3'd6;
                state_next = S_EXPM;
            end
            S_EXPM:
            begin
                cmd.op     = OP_EXPM;
                state_next = S_EXPD;
            end
            S_EXPD:
            begin
                cmd.op = OP_EXPD;
                if (n_reg == 3'd1)
                begin
                    state_next = S_PMUL;
                end
                else
                begin
                    n_next     = n_reg - 3'd1;
                    state_next = S_EXPM;
                end
            end
            S_PMUL:
            begin
                cmd.op     = OP_PMUL;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.op       = OP_FIN;
                cmd.path_end = path_end;
                end_next     = path_end;
                step_next    = path_end ? 16'd0 : step_inc;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit = '{load: 1'b1, sel_premium: 1'b0,
                             kind: end_reg ? KIND_PAYOFF : KIND_PRICE, last: end_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= 3'd6;
            step_reg  <= 16'd0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            step_reg  <= step_next;
            end_reg   <= end_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/gpop_datapath.sv
// Price step datapath: exponent, range reduction, Horner exp, scale, payoff.
// Depends on gpop_pkg.
`default_nettype none

module gpop_datapath
    import gpop_pkg::*;
#(
    parameter int PRICE_WIDTH  = 32,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                           clk,
    input  wire gpop_cmd_t                      cmd,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic [31:0]                    initial_price,
    input  wire logic [31:0]                    strike,
    input  wire logic signed [31:0]             drift_step,
    input  wire logic [30:0]                    vol_step,
    input  wire logic                           option_is_put,
    output logic [31:0]                         result
);

    localparam int PW   = PRICE_WIDTH;
    localparam int SF   = SAMPLE_WIDTH - 4;
    localparam int PDW  = SAMPLE_WIDTH + 32;
    localparam int MW   = PW + 30;
    localparam logic [PW-1:0]  PRICE_MAX = {PW{1'b1}};
    localparam logic [28:0]    ONE_Q28   = 29'(1) << EXP_FRAC;
    localparam logic [30:0]    MAGIC3    = 31'd1431655766;
    localparam logic [30:0]    MAGIC5    = 31'd858993460;
    localparam logic [30:0]    MAGIC6    = 31'd715827883;

    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic [PW-1:0]                  price_reg;
    logic signed [PDW-1:0]          p_reg;
    logic signed [XW-1:0]           x_reg;
    logic signed [15:0]             k_reg;
    logic signed [XW-1:0]           r_reg;
    logic [28:0]                    t_reg;
    logic [28:0]                    q_reg;
    logic [28:0]                    lo_part_reg;
    logic [PW+28:0]                 hi_prod_reg;
    logic [PW-1:0]                  res_reg;

    logic [PW-1:0]               init_sat;
    logic [PW-1:0]               strike_sat;
    logic signed [XW-17:0]       xh;
    logic signed [XW+5:0]        kest_prod;
    logic signed [44:0]          kl;
    logic [56:0]                 rt;
    logic [30:0]                 magic;
    logic [59:0]                 qm;
    logic [28:0]                 dq;
    logic [PW+27:0]              pext;
    logic [56:0]                 lo_prod;
    logic [MW-1:0]               m;
    logic [MW-1:0]               mr;
    logic [15:0]                 nk;
    logic [PW-1:0]               scaled;
    logic [PW-1:0]               payoff;

    assign init_sat   = ((64'(initial_price) >> PW) != 64'd0) ? PRICE_MAX : PW'(initial_price);
    assign strike_sat = ((64'(strike) >> PW) != 64'd0) ? PRICE_MAX : PW'(strike);

    assign xh        = x_reg[XW-1:16];
    assign kest_prod = xh * $signed({1'b0, RECIP_LN2});
    assign kl        = k_reg * $signed({1'b0, LN2_Q28});
    assign rt        = r_reg[27:0] * t_reg;

    // Horner divide by 1..6: shifts, or reciprocal multiply exact for 29-bit values
    always_comb
    begin
        magic = MAGIC3;
        case (cmd.n)
            3'd5:    magic = MAGIC5;
            3'd6:    magic = MAGIC6;
            default: magic = MAGIC3;
        endcase
        qm = q_reg * magic;
        case (cmd.n)
            3'd1:    dq = q_reg;
            3'd2:    dq = q_reg >> 1;
            3'd4:    dq = q_reg >> 2;
            default: dq = 29'(qm >> 32);
        endcase
    end

    assign pext    = (PW + 28)'(price_reg);
    assign lo_prod = pext[27:0] * t_reg;

    // Rescale by 2^k with saturation
    always_comb
    begin
        m      = MW'(hi_prod_reg) + MW'(lo_part_reg);
        nk     = 16'(-k_reg);
        mr     = m >> nk;
        scaled = '0;
        if ((m >> 64) != '0)
        begin
            scaled = PRICE_MAX;
        end
        else if (!k_reg[15])
        begin
            if (m == '0)
                scaled = '0;
            else if (k_reg >= PW)
                scaled = PRICE_MAX;
            else if ((m >> (PW - int'(k_reg))) != '0)
                scaled = PRICE_MAX;
            else
                scaled = PW'(m << k_reg);
        end
        else
        begin
            if (nk >= 16'd64)
                scaled = '0;
            else if ((mr >> PW) != '0)
                scaled = PRICE_MAX;
            else
                scaled = PW'(mr);
        end
    end

    always_comb
    begin
        if (option_is_put)
            payoff = (strike_sat > price_reg) ? strike_sat - price_reg : '0;
        else
            payoff = (price_reg > strike_sat) ? price_reg - strike_sat : '0;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                sample_reg <= sample;
                if (cmd.start)
                    price_reg <= init_sat;
            end
            OP_P:
            begin
                p_reg <= $signed({1'b0, vol_step}) * sample_reg;
            end
            OP_X:
            begin
                // arithmetic shift floors toward minus infinity
                x_reg <= XW'(drift_step) + XW'(p_reg >>> SF);
            end
            OP_KEST:
            begin
                k_reg <= 16'(kest_prod >>> 32);
            end
            OP_R:
            begin
                r_reg <= x_reg - XW'(kl);
            end
            OP_CORR:
            begin
                t_reg <= ONE_Q28;
                if (r_reg < 0)
                begin
                    k_reg <= k_reg - 16'sd1;
                    r_reg <= r_reg + XW'(LN2_Q28);
                end
                else if (r_reg >= $signed(XW'(LN2_Q28)))
                begin
                    k_reg <= k_reg + 16'sd1;
                    r_reg <= r_reg - XW'(LN2_Q28);
                end
            end
            OP_EXPM:
            begin
                q_reg <= rt[56:28];
            end
            OP_EXPD:
            begin
                t_reg <= ONE_Q28 + dq;
            end
            OP_PMUL:
            begin
                lo_part_reg <= lo_prod[56:28];
                hi_prod_reg <= pext[PW+27:28] * t_reg;
            end
            OP_SCALE:
            begin
                price_reg <= scaled;
            end
            OP_FIN:
            begin
                res_reg <= cmd.path_end ? payoff : price_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign result = 32'(res_reg);

endmodule

`default_nettype wire

>>> rtl/gbm_path_option_payoff_top.sv
// Top level of the path price / option payoff block: configuration registers,
// result output register, controller and datapath. Depends on gpop_pkg and gpop_if.
`default_nettype none

// One normal sample advances the underlying price by one geometric Brownian
// motion step: x = drift_step + vol_step * sample, price *= exp(x), with exp
// formed by ln 2 range reduction, a degree-six Horner series and a shift, and
// the price saturating at its maximum. The first sample of a path first
// transfers the premium (kind 0); each sample then transfers the new price
// (kind 1), but step number step_count (1 if step_count is 0) transfers the
// call or put payoff (kind 2) with last set, and the next sample starts a new
// path from initial_price. A sample goes from its transfer through exponent
// forming and ln 2 range reduction, six Horner rounds of one multiply and one
// divide each, then the price multiply, the rescale and the result select, and
// its result is loaded in the output register when that register is free. The
// next sample is taken from the cycle in which the last result sits in the
// output register, so the block takes no new sample while one is in work; a
// full output register holds back the premium or the result and stalls the block.
// Write configuration only while the block is idle.

module gbm_path_option_payoff_top
    import gpop_pkg::*;
#(
    parameter int PRICE_WIDTH  = 32,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    gpop_in_if.sink          sample_ch,
    gpop_out_if.source       result_ch
);

    // Configuration registers
    logic [31:0]        premium_reg;
    logic [31:0]        initial_price_reg;
    logic [31:0]        strike_reg;
    logic signed [31:0] drift_step_reg;
    logic [30:0]        vol_step_reg;
    logic               option_is_put_reg;
    logic [15:0]        step_count_reg;

    // Output register
    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic [1:0]  out_kind_reg;
    logic        out_last_reg;

    gpop_cmd_t   cmd;
    gpop_emit_t  emit;
    logic        out_free;
    logic [31:0] dp_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            premium_reg       <= 32'd0;
            initial_price_reg <= 32'd65536;
            strike_reg        <= 32'd65536;
            drift_step_reg    <= 32'sd0;
            vol_step_reg      <= 31'd0;
            option_is_put_reg <= 1'b0;
            step_count_reg    <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PREMIUM:       premium_reg       <= cfg_data;
                REG_INITIAL_PRICE: initial_price_reg <= cfg_data;
                REG_STRIKE:        strike_reg        <= cfg_data;
                REG_DRIFT_STEP:    drift_step_reg    <= $signed(cfg_data);
                REG_VOL_STEP:      vol_step_reg      <= cfg_data[30:0];
                REG_OPTION_IS_PUT: option_is_put_reg <= cfg_data[0];
                REG_STEP_COUNT:    step_count_reg    <= cfg_data[15:0];
                default:
                begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || result_ch.ready;

    gpop_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (sample_ch.valid),
        .in_ready   (sample_ch.ready),
        .out_free   (out_free),
        .step_count (step_count_reg),
        .cmd        (cmd),
        .emit       (emit)
    );

    gpop_datapath #(
        .PRICE_WIDTH  (PRICE_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .cmd           (cmd),
        .sample        (sample_ch.normal_sample),
        .initial_price (initial_price_reg),
        .strike        (strike_reg),
        .drift_step    (drift_step_reg),
        .vol_step      (vol_step_reg),
        .option_is_put (option_is_put_reg),
        .result        (dp_result)
    );

    // Hold a result until its transfer; load the next one in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load)
        begin
            out_value_reg <= emit.sel_premium ? premium_reg : dp_result;
            out_kind_reg  <= emit.kind;
            out_last_reg  <= emit.last;
        end
    end

    assign result_ch.valid = out_valid_reg;
    assign result_ch.value = out_value_reg;
    assign result_ch.kind  = out_kind_reg;
    assign result_ch.last  = out_last_reg;

endmodule

`default_nettype wire
